>>> hw/rtl/acia_pkg.sv
// Shared types and constants of the serial interface register model.
package acia_pkg;

	localparam int ACIA_FIFO_DEPTH = 256;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_RECV  = 2'd2,
		CMD_NONE  = 2'd3
	} bus_cmd_t;

	typedef enum logic [1:0] {
		SEL_DATA    = 2'd0,
		SEL_STATUS  = 2'd1,
		SEL_COMMAND = 2'd2,
		SEL_CONTROL = 2'd3
	} reg_sel_t;

	// command register: bit1 masks the receive interrupt, bits 3..2 = 01 unmask transmit
	localparam logic [7:0] CMDREG_RX_IRQ_OFF = 8'h02;
	localparam logic [7:0] CMDREG_TX_FIELD   = 8'h0C;
	localparam logic [7:0] CMDREG_TX_IRQ_ON  = 8'h04;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       irq;
	} acia_result_t;

endpackage

>>> hw/rtl/acia_fifo_mem.sv
// Receive FIFO storage: one write port, one read port with registered data.
module acia_fifo_mem
	import acia_pkg::*;
#(
	parameter int FIFO_DEPTH = ACIA_FIFO_DEPTH,
	localparam int AW = $clog2(FIFO_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [FIFO_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/acia_core.sv
// Register update logic: status, command, control, holding register and FIFO pointers.
module acia_core
	import acia_pkg::*;
#(
	parameter int FIFO_DEPTH = ACIA_FIFO_DEPTH,
	localparam int AW = $clog2(FIFO_DEPTH),
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  bus_cmd_t      cmd,
	input  reg_sel_t      sel,
	input  logic [7:0]    value,
	output acia_result_t  result,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	logic [7:0]    holding_q;
	logic          refill_s1;
	logic [7:0]    cmd_reg_q, ctl_reg_q;
	logic          tdre_q, rdrf_q, ovr_q, irq_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	logic [7:0]    holding_cur;
	logic [7:0]    cmd_reg_d, ctl_reg_d;
	logic          tdre_d, rdrf_d, ovr_d, irq_d;
	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	logic          hold_load;

	function automatic logic want_irq(input logic rdrf, input logic tdre,
			input logic [7:0] creg);
		want_irq = (rdrf && ((creg & CMDREG_RX_IRQ_OFF) == 8'h00)) ||
			(tdre && ((creg & CMDREG_TX_FIELD) == CMDREG_TX_IRQ_ON));
	endfunction

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Holding byte refilled last cycle is still in the memory read register
	assign holding_cur = refill_s1 ? mem_rdata : holding_q;
	assign mem_wdata   = value;
	assign mem_waddr   = head_q;
	assign mem_raddr   = tail_q;

	always_comb begin
		cmd_reg_d = cmd_reg_q;
		ctl_reg_d = ctl_reg_q;
		tdre_d    = tdre_q;
		rdrf_d    = rdrf_q;
		ovr_d     = ovr_q;
		irq_d     = irq_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		hold_load = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		result    = '0;
		unique case (cmd)
			CMD_READ: begin
				unique case (sel)
					SEL_DATA: begin
						result.read_data = holding_cur;
						rdrf_d = 1'b0;
						ovr_d  = 1'b0;
						irq_d  = 1'b0;
						if (count_q != '0) begin
							mem_re  = accept;
							tail_d  = ptr_next(tail_q);
							count_d = count_q - 1'b1;
							rdrf_d  = 1'b1;
							irq_d   = want_irq(1'b1, tdre_q, cmd_reg_q);
						end
					end
					SEL_STATUS:  result.read_data = {irq_q, 2'b00, tdre_q, rdrf_q, ovr_q, 2'b00};
					SEL_COMMAND: result.read_data = cmd_reg_q;
					SEL_CONTROL: result.read_data = ctl_reg_q;
					default:     result.read_data = '0;
				endcase
			end
			CMD_WRITE: begin
				unique case (sel)
					SEL_DATA: begin
						result.tx_valid = 1'b1;
						result.tx_byte  = value;
						tdre_d = 1'b1;
					end
					SEL_STATUS: begin
						// programmed reset: clear errors and transmit control
						ovr_d     = 1'b0;
						irq_d     = 1'b0;
						cmd_reg_d = cmd_reg_q & ~CMDREG_TX_FIELD;
					end
					SEL_COMMAND: begin
						cmd_reg_d = value;
						irq_d     = want_irq(rdrf_q, tdre_q, value);
					end
					SEL_CONTROL: ctl_reg_d = value;
					default: ;
				endcase
			end
			CMD_RECV: begin
				if (count_q == CW'(FIFO_DEPTH)) begin
					ovr_d = 1'b1;
				end else begin
					if (!rdrf_q) begin
						hold_load = 1'b1;
						rdrf_d    = 1'b1;
					end else begin
						mem_we  = accept;
						head_d  = ptr_next(head_q);
						count_d = count_q + 1'b1;
					end
					irq_d = want_irq(1'b1, tdre_q, cmd_reg_q);
				end
			end
			CMD_NONE: ;
			default: ;
		endcase
		result.irq = irq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_reg_q <= '0;
			ctl_reg_q <= '0;
			tdre_q    <= 1'b1;
			rdrf_q    <= 1'b0;
			ovr_q     <= 1'b0;
			irq_q     <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			refill_s1 <= 1'b0;
			holding_q <= '0;
		end else begin
			refill_s1 <= mem_re;
			// refill and a direct load never meet: refill leaves RDRF set
			if (refill_s1) begin
				holding_q <= mem_rdata;
			end else if (accept && hold_load) begin
				holding_q <= value;
			end
			if (accept) begin
				cmd_reg_q <= cmd_reg_d;
				ctl_reg_q <= ctl_reg_d;
				tdre_q    <= tdre_d;
				rdrf_q    <= rdrf_d;
				ovr_q     <= ovr_d;
				irq_q     <= irq_d;
				head_q    <= head_d;
				tail_q    <= tail_d;
				count_q   <= count_d;
			end
		end
	end

endmodule

>>> hw/rtl/acia_out_buf.sv
// Output register with a skid stage for result items.
module acia_out_buf
	import acia_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_accept,
	input  acia_result_t in_result,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output acia_result_t out_result
);

	logic         out_valid_q, skid_valid_q;
	acia_result_t out_q, skid_q;
	logic         take;

	assign take       = out_valid_q && out_ready;
	assign in_ready   = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_accept;
			end
		end else if (in_accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_accept) begin
				out_q <= in_result;
			end
		end else if (in_accept) begin
			if (!out_valid_q) begin
				out_q <= in_result;
			end else begin
				skid_q <= in_result;
			end
		end
	end

endmodule

>>> hw/rtl/uart_acia_register_model.sv
// Top level of the serial interface register model.
//
// A 6551-style serial interface register model with a receive FIFO. Each input
// item is a bus read, a bus write or a byte received from the serial line, and
// each produces exactly one result item carrying the read data, the transmit
// byte with its valid flag, and the interrupt line level after the item. Items
// are taken one per clock while input ready is high: all register and pointer
// updates happen in the cycle an item is accepted, and the FIFO memory (one
// write port, one read port with a registered read) is read at the tail pointer
// when a data-register read pops an entry. The popped byte lands in the holding
// register in the next cycle and is forwarded from the memory read register, so
// a data read right behind another still sees the new byte. A FIFO write and
// read never hit the same entry in one cycle. Results pass through an output
// register plus a skid stage; input ready drops only while both are full. After
// reset the FIFO is empty, the status reads 0x10 (transmitter empty) and no
// clearing pass is needed.
module uart_acia_register_model
	import acia_pkg::*;
#(
	parameter int FIFO_DEPTH = ACIA_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] value
	input  logic [3:0]  s_tuser,   // [1:0] command, [3:2] reg_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] read_data, [15:8] tx_byte, [16] irq, [23:17] zero
	output logic [0:0]  m_tuser    // [0] tx_valid
);

	localparam int AW = $clog2(FIFO_DEPTH);

	logic          accept;
	acia_result_t  res_d, res_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	assign accept = s_tvalid && s_tready;

	acia_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (bus_cmd_t'(s_tuser[1:0])),
		.sel       (reg_sel_t'(s_tuser[3:2])),
		.value     (s_tdata),
		.result    (res_d),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	acia_fifo_mem #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Hold results here while the sink stalls; keep taking items until the skid stage is full too
	acia_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (accept),
		.in_result  (res_d),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (res_q)
	);

	assign m_tdata = {7'd0, res_q.irq, res_q.tx_byte, res_q.read_data};
	assign m_tuser = res_q.tx_valid;

endmodule
